### sv/pfdr_pkg.sv
// ----------------------------------------------------------------------------
// pfdr_pkg
// Shared widths, codes, state types and unit result structs for the
// prime field divide/reduce block.
// ----------------------------------------------------------------------------
package pfdr_pkg;

   localparam int MOD_W          = 31;                  // field element / modulus width
   localparam int DATA_W_DEFAULT = 32;                  // default input operand width
   localparam int T_W            = MOD_W + 3;           // signed Bezout coefficient width
   localparam int SH_W           = $clog2(MOD_W);       // shift count in the Euclid unit
   localparam int CNT_MW         = $clog2(MOD_W + 1);   // bit counter over MOD_W bits

   localparam logic CMD_REDUCE = 1'b0;
   localparam logic CMD_DIVIDE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RES_A,
      ST_RES_B,
      ST_EUCLID,
      ST_DIVIDE,
      ST_MULT,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      EU_IDLE,
      EU_CHECK,
      EU_ALIGN,
      EU_SUB,
      EU_FINAL
   } eu_phase_type;

   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] value;
   } serial_res_type;

   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] quotient;
      logic             exact;
   } div_res_type;

   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] gcd;
      logic [MOD_W-1:0] cofactor;   // modulus / gcd
      logic [MOD_W-1:0] inverse;    // (b / gcd)^-1 mod cofactor
   } euclid_res_type;

endpackage

### sv/pfdr_residue.sv
// ----------------------------------------------------------------------------
// pfdr_residue
// Bit-serial signed residue: magnitude shifted in MSB first, one
// compare/subtract per bit, then a sign fix-up step.
// ----------------------------------------------------------------------------
module pfdr_residue #(
   parameter int DATA_WIDTH = pfdr_pkg::DATA_W_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [DATA_WIDTH-1:0]  value,
   input  logic [pfdr_pkg::MOD_W-1:0]    modulus,
   output pfdr_pkg::serial_res_type      res
);
   import pfdr_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  fix_ff, fix_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [MOD_W-1:0]      m_ff, m_in;
   logic [MOD_W-1:0]      rem_ff, rem_in;

   logic [MOD_W:0] trial;
   logic [MOD_W:0] trial_red;

   always_comb begin
      trial     = {rem_ff, mag_ff[DATA_WIDTH-1]};
      trial_red = (trial >= {1'b0, m_ff}) ? trial - {1'b0, m_ff} : trial;

      busy_in = busy_ff;
      fix_in  = fix_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      m_in    = m_ff;
      rem_in  = rem_ff;

      if (start) begin
         mag_in  = value[DATA_WIDTH-1] ? $unsigned(-value) : $unsigned(value);
         neg_in  = value[DATA_WIDTH-1];
         m_in    = modulus;
         rem_in  = '0;
         cnt_in  = CNT_W'(DATA_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = trial_red[MOD_W-1:0];
         mag_in = {mag_ff[DATA_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         // negative input: residue of |v| maps to m - r
         if (neg_ff && rem_ff != '0) begin
            rem_in = m_ff - rem_ff;
         end
         fix_in  = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      m_ff   <= m_in;
      rem_ff <= rem_in;
   end

   assign res.done  = done_ff;
   assign res.value = rem_ff;

endmodule

### sv/pfdr_euclid.sv
// ----------------------------------------------------------------------------
// pfdr_euclid
// Extended Euclid on (modulus, b). Each quotient is built by shift/subtract:
// the divisor is aligned up one bit a cycle, then walked back down,
// subtracting where it fits and tracking the b coefficient alongside.
// ----------------------------------------------------------------------------
module pfdr_euclid (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pfdr_pkg::MOD_W-1:0] modulus,
   input  logic [pfdr_pkg::MOD_W-1:0] b,
   output pfdr_pkg::euclid_res_type   res
);
   import pfdr_pkg::*;

   eu_phase_type          phase_ff, phase_in;
   logic [MOD_W-1:0]      r0_ff, r0_in;
   logic [MOD_W-1:0]      r1_ff, r1_in;
   logic signed [T_W-1:0] t0_ff, t0_in;
   logic signed [T_W-1:0] t1_ff, t1_in;
   logic [MOD_W-1:0]      d_ff, d_in;
   logic signed [T_W-1:0] td_ff, td_in;
   logic [SH_W-1:0]       k_ff, k_in;
   logic                  done_ff, done_in;
   logic [MOD_W-1:0]      gcd_ff, gcd_in;
   logic [MOD_W-1:0]      cof_ff, cof_in;
   logic [MOD_W-1:0]      inv_ff, inv_in;

   logic [MOD_W:0]        d_dbl;
   logic                  dbl_fits;
   logic                  sub_ok;
   logic [MOD_W-1:0]      r0_sub;
   logic signed [T_W-1:0] t0_sub;
   logic signed [T_W-1:0] t1_abs;
   logic signed [T_W-1:0] inv_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= EU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      d_ff   <= d_in;
      td_ff  <= td_in;
      k_ff   <= k_in;
      gcd_ff <= gcd_in;
      cof_ff <= cof_in;
      inv_ff <= inv_in;
   end

   always_comb begin
      d_dbl    = {d_ff, 1'b0};
      dbl_fits = d_dbl <= {1'b0, r0_ff};
      sub_ok   = d_ff <= r0_ff;
      r0_sub   = sub_ok ? r0_ff - d_ff : r0_ff;
      t0_sub   = sub_ok ? t0_ff - td_ff : t0_ff;
      // at the end |t1| = modulus / gcd
      t1_abs   = t1_ff[T_W-1] ? -t1_ff : t1_ff;
      inv_full = t0_ff[T_W-1] ? t0_ff + t1_abs : t0_ff;

      phase_in = phase_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      d_in     = d_ff;
      td_in    = td_ff;
      k_in     = k_ff;
      done_in  = 1'b0;
      gcd_in   = gcd_ff;
      cof_in   = cof_ff;
      inv_in   = inv_ff;

      unique case (phase_ff)
         EU_IDLE: begin
            if (start) begin
               r0_in    = modulus;
               r1_in    = b;
               t0_in    = '0;
               t1_in    = T_W'(1);
               phase_in = EU_CHECK;
            end
         end
         EU_CHECK: begin
            if (r1_ff == '0) begin
               phase_in = EU_FINAL;
            end else begin
               d_in     = r1_ff;
               td_in    = t1_ff;
               k_in     = '0;
               phase_in = EU_ALIGN;
            end
         end
         EU_ALIGN: begin
            if (dbl_fits) begin
               d_in  = d_dbl[MOD_W-1:0];
               td_in = td_ff <<< 1;
               k_in  = k_ff + SH_W'(1);
            end else begin
               phase_in = EU_SUB;
            end
         end
         EU_SUB: begin
            if (k_ff == '0) begin
               // last quotient bit: remainder done, rotate the pairs
               r0_in    = r1_ff;
               r1_in    = r0_sub;
               t0_in    = t1_ff;
               t1_in    = t0_sub;
               phase_in = EU_CHECK;
            end else begin
               r0_in = r0_sub;
               t0_in = t0_sub;
               d_in  = {1'b0, d_ff[MOD_W-1:1]};
               td_in = td_ff >>> 1;
               k_in  = k_ff - SH_W'(1);
            end
         end
         EU_FINAL: begin
            gcd_in   = r0_ff;
            cof_in   = t1_abs[MOD_W-1:0];
            inv_in   = inv_full[MOD_W-1:0];
            done_in  = 1'b1;
            phase_in = EU_IDLE;
         end
         default: begin
            phase_in = EU_IDLE;
         end
      endcase
   end

   assign res.done     = done_ff;
   assign res.gcd      = gcd_ff;
   assign res.cofactor = cof_ff;
   assign res.inverse  = inv_ff;

endmodule

### sv/pfdr_divider.sv
// ----------------------------------------------------------------------------
// pfdr_divider
// Bit-serial restoring divider: one quotient bit per cycle, dividend and
// quotient share one shift register.
// ----------------------------------------------------------------------------
module pfdr_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pfdr_pkg::MOD_W-1:0] dividend,
   input  logic [pfdr_pkg::MOD_W-1:0] divisor,
   output pfdr_pkg::div_res_type      res
);
   import pfdr_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_MW-1:0] cnt_ff, cnt_in;
   logic [MOD_W-1:0]  quo_ff, quo_in;
   logic [MOD_W-1:0]  rem_ff, rem_in;
   logic [MOD_W-1:0]  div_ff, div_in;

   logic [MOD_W:0]    trial;
   logic              fits;

   always_comb begin
      trial = {rem_ff, quo_ff[MOD_W-1]};
      fits  = trial >= {1'b0, div_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;

      if (start) begin
         quo_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNT_MW'(MOD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? MOD_W'(trial - {1'b0, div_ff}) : trial[MOD_W-1:0];
         quo_in = {quo_ff[MOD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_MW'(1);
         if (cnt_ff == CNT_MW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;
   assign res.exact    = (rem_ff == '0);

endmodule

### sv/pfdr_mulmod.sv
// ----------------------------------------------------------------------------
// pfdr_mulmod
// Bit-serial modular multiply, MSB first double-and-add. Each multiplier
// bit takes a doubling step, then a conditional add step, each reduced once.
// ----------------------------------------------------------------------------
module pfdr_mulmod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pfdr_pkg::MOD_W-1:0] mult_q,
   input  logic [pfdr_pkg::MOD_W-1:0] mult_y,
   input  logic [pfdr_pkg::MOD_W-1:0] modulus,
   output pfdr_pkg::serial_res_type   res
);
   import pfdr_pkg::*;

   logic              busy_ff, busy_in;
   logic              add_ff, add_in;     // 0: doubling cycle, 1: add cycle
   logic              done_ff, done_in;
   logic [CNT_MW-1:0] cnt_ff, cnt_in;
   logic [MOD_W-1:0]  q_ff, q_in;
   logic [MOD_W-1:0]  y_ff, y_in;
   logic [MOD_W-1:0]  n_ff, n_in;
   logic [MOD_W-1:0]  acc_ff, acc_in;

   logic [MOD_W-1:0]  addend;
   logic [MOD_W:0]    sum;
   logic [MOD_W:0]    sum_red;

   always_comb begin
      // operands stay below n, so one subtract brings the sum back in range
      if (add_ff) begin
         addend = q_ff[MOD_W-1] ? y_ff : '0;
      end else begin
         addend = acc_ff;
      end
      sum     = {1'b0, acc_ff} + {1'b0, addend};
      sum_red = (sum >= {1'b0, n_ff}) ? sum - {1'b0, n_ff} : sum;

      busy_in = busy_ff;
      add_in  = add_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      y_in    = y_ff;
      n_in    = n_ff;
      acc_in  = acc_ff;

      if (start) begin
         q_in    = mult_q;
         y_in    = mult_y;
         n_in    = modulus;
         acc_in  = '0;
         add_in  = 1'b0;
         cnt_in  = CNT_MW'(MOD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum_red[MOD_W-1:0];
         add_in = !add_ff;
         if (add_ff) begin
            q_in   = {q_ff[MOD_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_MW'(1);
            if (cnt_ff == CNT_MW'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         add_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         add_ff  <= add_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      y_ff   <= y_in;
      n_ff   <= n_in;
      acc_ff <= acc_in;
   end

   assign res.done  = done_ff;
   assign res.value = acc_ff;

endmodule

### sv/prime_field_divide_reduce_top.sv
// ----------------------------------------------------------------------------
// prime_field_divide_reduce_top
// Reduce: the residue of value_a, from the bit-serial residue unit (one input
// bit per cycle). Divide: residues of value_a and value_b, the extended Euclid
// loop on the modulus and b's residue, a divide of a's residue by the gcd,
// then a multiply by the inverse modulo the cofactor.
// One transaction in flight; a finished result may wait in the output register
// while the next transaction is accepted. Synchronous reset: idle, no result
// pending, modulus back to 2.
// ----------------------------------------------------------------------------
module prime_field_divide_reduce_top #(
   parameter int DATA_WIDTH = pfdr_pkg::DATA_W_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_value_a,
   input  logic signed [DATA_WIDTH-1:0] req_value_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pfdr_pkg::MOD_W-1:0]   rsp_field_value,
   output logic                         rsp_no_solution,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pfdr_pkg::MOD_W-1:0]   csr_modulus
);
   import pfdr_pkg::*;

   state_type                    state_ff, state_in;
   logic [MOD_W-1:0]             modulus_ff, modulus_in;
   logic                         cmd_ff, cmd_in;
   logic signed [DATA_WIDTH-1:0] b_raw_ff, b_raw_in;
   logic [MOD_W-1:0]             a_res_ff, a_res_in;
   logic [MOD_W-1:0]             field_ff, field_in;
   logic                         flag_ff, flag_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [MOD_W-1:0]             rsp_field_ff, rsp_field_in;
   logic                         rsp_flag_ff, rsp_flag_in;

   logic [MOD_W-1:0]             m_eff;
   logic                         res_start, eu_start, dv_start, mm_start;
   logic signed [DATA_WIDTH-1:0] res_value;
   serial_res_type               res_out;
   euclid_res_type               eu_out;
   div_res_type                  dv_out;
   serial_res_type               mm_out;

   // modulus zero behaves as modulus one
   assign m_eff = (modulus_ff == '0) ? MOD_W'(1) : modulus_ff;

   pfdr_residue #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_residue (
      .clock   (clock),
      .reset   (reset),
      .start   (res_start),
      .value   (res_value),
      .modulus (m_eff),
      .res     (res_out)
   );

   pfdr_euclid u_euclid (
      .clock   (clock),
      .reset   (reset),
      .start   (eu_start),
      .modulus (m_eff),
      .b       (res_out.value),
      .res     (eu_out)
   );

   pfdr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (a_res_ff),
      .divisor  (eu_out.gcd),
      .res      (dv_out)
   );

   pfdr_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .mult_q  (dv_out.quotient),
      .mult_y  (eu_out.inverse),
      .modulus (eu_out.cofactor),
      .res     (mm_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= MOD_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      b_raw_ff     <= b_raw_in;
      a_res_ff     <= a_res_in;
      field_ff     <= field_in;
      flag_ff      <= flag_in;
      rsp_field_ff <= rsp_field_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   always_comb begin
      state_in     = state_ff;
      modulus_in   = modulus_ff;
      cmd_in       = cmd_ff;
      b_raw_in     = b_raw_ff;
      a_res_in     = a_res_ff;
      field_in     = field_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_field_in = rsp_field_ff;
      rsp_flag_in  = rsp_flag_ff;
      res_start    = 1'b0;
      eu_start     = 1'b0;
      dv_start     = 1'b0;
      mm_start     = 1'b0;

      // value_a goes straight from the port at accept, value_b later
      res_value = (state_ff == ST_IDLE) ? req_value_a : b_raw_ff;

      req_stall = (state_ff != ST_IDLE);
      // no modulus write in the cycle a transaction is taken
      csr_ready = (state_ff == ST_IDLE) && !req_valid;

      if (csr_valid && csr_ready) begin
         modulus_in = csr_modulus;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               b_raw_in  = req_value_b;
               res_start = 1'b1;
               state_in  = ST_RES_A;
            end
         end
         ST_RES_A: begin
            if (res_out.done) begin
               a_res_in = res_out.value;
               if (cmd_ff == CMD_REDUCE) begin
                  field_in = res_out.value;
                  flag_in  = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  res_start = 1'b1;
                  state_in  = ST_RES_B;
               end
            end
         end
         ST_RES_B: begin
            if (res_out.done) begin
               eu_start = 1'b1;
               state_in = ST_EUCLID;
            end
         end
         ST_EUCLID: begin
            if (eu_out.done) begin
               dv_start = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (dv_out.done) begin
               if (!dv_out.exact) begin
                  // gcd does not divide the numerator: no solution
                  field_in = '0;
                  flag_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  mm_start = 1'b1;
                  state_in = ST_MULT;
               end
            end
         end
         ST_MULT: begin
            if (mm_out.done) begin
               field_in = mm_out.value;
               flag_in  = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_field_in = field_ff;
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_value = rsp_field_ff;
   assign rsp_no_solution = rsp_flag_ff;

endmodule

### sv/pfdr_checker.sv
// ----------------------------------------------------------------------------
// pfdr_checker
// Port-level checks for the prime field divide/reduce block, bound to the
// top level.
// ----------------------------------------------------------------------------
module pfdr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [pfdr_pkg::MOD_W-1:0] rsp_field_value,
   input logic                       rsp_no_solution,
   input logic                       csr_ready
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_field_value)
                                 && $stable(rsp_no_solution))
      else $error("stalled result changed or dropped");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_solution |-> rsp_field_value == '0)
      else $error("no_solution result with nonzero field value");

   // one transaction at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a transaction is in progress");

   a_csr_idle_only: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !req_stall)
      else $error("modulus write open while busy");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind prime_field_divide_reduce_top pfdr_checker u_pfdr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_field_value (rsp_field_value),
   .rsp_no_solution (rsp_no_solution),
   .csr_ready       (csr_ready)
);

### test/prime_field_divide_reduce_top_tb.sv
// ----------------------------------------------------------------------------
// prime_field_divide_reduce_top_tb
// Drives reduce and divide transactions into the prime field unit under
// several modulus settings (reset value, zero, one, primes, composites, the
// 31-bit maximum) and compares every result against an in-bench model of
// the field arithmetic. Both handshakes see random gaps, and one long receiver
// hold-off backs the unit up into its input.
// ----------------------------------------------------------------------------
module prime_field_divide_reduce_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfdr_pkg::*;

   localparam int DATA_W          = 32;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int TAIL_CYCLES     = 500;
   localparam int HOLD_OFF_CYCLES = 600;

   typedef struct packed {
      logic [MOD_W-1:0] element;
      logic             no_solution;
   } field_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_cmd;
   logic signed [DATA_W-1:0] req_value_a;
   logic signed [DATA_W-1:0] req_value_b;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [MOD_W-1:0]         rsp_field_value;
   logic                     rsp_no_solution;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [MOD_W-1:0]         csr_modulus;

   field_result_type results_due[$];
   field_result_type oldest_due;
   logic [MOD_W-1:0] modulus_setting;
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   int               hold_off_request = 0;
   bit               holding_off = 0;
   bit               tx_quiet = 0;
   bit               rx_quiet = 0;

   prime_field_divide_reduce_top #(
      .DATA_WIDTH(DATA_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_value_a(req_value_a),
      .req_value_b(req_value_b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_field_value(rsp_field_value),
      .rsp_no_solution(rsp_no_solution),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_modulus(csr_modulus)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(50, 300);
   endfunction

   function automatic longint unsigned residue_of(logic signed [DATA_W-1:0] v,
                                                  longint unsigned m);
      longint s;
      longint r;
      s = v;
      r = s % longint'(m);
      if (r < 0) r += longint'(m);
      return longint'(r);
   endfunction

   function automatic field_result_type field_result_for(logic cmd,
                                                         logic signed [DATA_W-1:0] a,
                                                         logic signed [DATA_W-1:0] b,
                                                         logic [MOD_W-1:0] p);
      longint unsigned  m, ra, rb, x, y, t, g, mg, ub, fv;
      longint           r0, r1, t0, t1, q, tmp;
      field_result_type res;
      m  = (p == '0) ? 1 : p;
      ra = residue_of(a, m);
      fv = ra;
      res.no_solution = 1'b0;
      if (cmd == CMD_DIVIDE) begin
         rb = residue_of(b, m);
         // gcd(rb, m); a zero denominator gives m itself
         x = rb;
         y = m;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         g = x;
         if (ra % g != 0) begin
            fv = 0;
            res.no_solution = 1'b1;
         end else begin
            mg = m / g;
            ub = (rb / g) % mg;
            r0 = longint'(mg);
            r1 = longint'(ub);
            t0 = 0;
            t1 = 1;
            while (r1 != 0) begin
               q   = r0 / r1;
               tmp = r0 - q * r1;
               r0  = r1;
               r1  = tmp;
               tmp = t0 - q * t1;
               t0  = t1;
               t1  = tmp;
            end
            if (t0 < 0) t0 += longint'(mg);
            fv = ((ra / g) % mg) * (longint'(t0) % mg) % mg;
         end
      end
      res.element = fv[MOD_W-1:0];
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] pick_operand(longint unsigned m);
      longint          v;
      logic [DATA_W-1:0] word;
      v = 0;
      case ($urandom_range(0, 7))
         0, 1, 2: word = $urandom;
         3: begin
            v = longint'($urandom_range(0, 40)) - 20;
            word = v[DATA_W-1:0];
         end
         4: begin
            v = (longint'($urandom_range(0, 6)) - 3) * longint'(m);
            word = v[DATA_W-1:0];
         end
         5: begin
            case ($urandom_range(0, 3))
               0: word = 32'h8000_0000;
               1: word = 32'h7fff_ffff;
               2: word = '1;
               default: word = '0;
            endcase
         end
         6: begin
            v = longint'(m) + longint'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1)) v = -v;
            word = v[DATA_W-1:0];
         end
         default: begin
            v = longint'($urandom % m);
            word = v[DATA_W-1:0];
         end
      endcase
      return word;
   endfunction

   task automatic offer_item(logic cmd, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      int gap;
      gap = tx_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_value_a <= a;
      req_value_b <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      results_due.push_back(field_result_for(cmd, a, b, modulus_setting));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_modulus(logic [MOD_W-1:0] p);
      drain_results();
      csr_valid   <= 1'b1;
      csr_modulus <= p;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      modulus_setting = p;
      @(posedge clock);
   endtask

   // modulus still at its reset value of two
   task automatic test_reset_modulus();
      offer_item(CMD_REDUCE, -32'sd1, 32'd0);
      offer_item(CMD_REDUCE, 32'h8000_0000, 32'd5);
      offer_item(CMD_DIVIDE, 32'd1, 32'd1);
      offer_item(CMD_DIVIDE, 32'd1, 32'd2);
      offer_item(CMD_DIVIDE, 32'd0, 32'd0);
   endtask

   task automatic test_reduce_extremes();
      set_modulus(31'h7fff_ffff);
      offer_item(CMD_REDUCE, 32'h8000_0000, 32'hffff_ffff);
      offer_item(CMD_REDUCE, 32'h7fff_ffff, 32'h8000_0000);
      offer_item(CMD_REDUCE, 32'hffff_ffff, 32'h7fff_ffff);
      offer_item(CMD_REDUCE, 32'd0, 32'd0);
      offer_item(CMD_REDUCE, 32'd1, 32'd3);
      offer_item(CMD_REDUCE, 32'h8000_0001, 32'd0);
   endtask

   // zero denominators, numerators that vanish mod p, negative operands
   task automatic test_divide_cases();
      offer_item(CMD_DIVIDE, 32'h7fff_ffff, 32'd3);
      offer_item(CMD_DIVIDE, 32'd1, 32'hffff_ffff);
      offer_item(CMD_DIVIDE, 32'h8000_0000, 32'h8000_0000);
      offer_item(CMD_DIVIDE, 32'd5, 32'd0);
      offer_item(CMD_DIVIDE, 32'd0, 32'h7fff_ffff);
      offer_item(CMD_DIVIDE, 32'd7, 32'h7fff_ffff);
   endtask

   // zero modulus acts as one; a composite modulus may or may not divide
   task automatic test_degenerate_moduli();
      set_modulus(31'd0);
      offer_item(CMD_REDUCE, -32'sd7, 32'd0);
      offer_item(CMD_DIVIDE, 32'd3, 32'd0);
      set_modulus(31'd1);
      offer_item(CMD_DIVIDE, 32'd5, 32'd2);
      set_modulus(31'd12);
      offer_item(CMD_DIVIDE, 32'd4, 32'd6);
      offer_item(CMD_DIVIDE, 32'd8, 32'd4);
      offer_item(CMD_DIVIDE, 32'd9, -32'sd3);
   endtask

   task automatic test_output_backpressure();
      set_modulus(31'd65537);
      hold_off_request = HOLD_OFF_CYCLES;
      while (!holding_off) @(posedge clock);
      tx_quiet = 1'b1;
      repeat (8) offer_item(CMD_REDUCE, $urandom, $urandom);
      tx_quiet = 1'b0;
      drain_results();
   endtask

   task automatic test_random_traffic(logic [MOD_W-1:0] p, int count);
      longint unsigned m;
      logic            cmd;
      set_modulus(p);
      m = (p == '0) ? 1 : p;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
         end
         cmd = ($urandom_range(0, 2) != 0) ? CMD_DIVIDE : CMD_REDUCE;
         offer_item(cmd, pick_operand(m), pick_operand(m));
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request > 0) begin
            n = hold_off_request;
            hold_off_request = 0;
            holding_off = 1'b1;
         end else begin
            n = rx_quiet ? 0 : pick_gap();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         holding_off = 1'b0;
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (results_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual %0d/%0b",
                     $time, rsp_field_value, rsp_no_solution);
         end else begin
            oldest_due = results_due.pop_front();
            if (rsp_field_value !== oldest_due.element) begin
               mismatch_count++;
               $display("%0t: field_value expected %0d, actual %0d",
                        $time, oldest_due.element, rsp_field_value);
            end
            if (rsp_no_solution !== oldest_due.no_solution) begin
               mismatch_count++;
               $display("%0t: no_solution expected %0b, actual %0b",
                        $time, oldest_due.no_solution, rsp_no_solution);
            end
         end
      end
   end

   // stall detector: any handshake clears the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_REDUCE;
      req_value_a     = '0;
      req_value_b     = '0;
      csr_valid       = 1'b0;
      csr_modulus     = '0;
      modulus_setting = 31'd2;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_modulus();
      test_reduce_extremes();
      test_divide_cases();
      test_degenerate_moduli();
      test_output_backpressure();
      test_random_traffic(31'd7, 200);
      test_random_traffic(31'h7fff_ffff, 300);
      test_random_traffic(31'd65537, 200);
      test_random_traffic(31'd360, 200);
      test_random_traffic(MOD_W'($urandom_range(2, 32'h7fff_ffff)), 250);
      test_random_traffic(31'h7fff_fffe, 200);
      test_random_traffic(31'd1, 50);
      test_random_traffic(31'd0, 50);
      test_random_traffic(31'd2, 50);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
